@@ rtl/core/gpp_pkg.sv @@
`default_nettype none

package gpp_pkg;

  // Field widths
  localparam int unsigned OP_W   = 2;
  localparam int unsigned ROW_W  = 7;
  localparam int unsigned DATA_W = 8;

  // Default table depth and height after reset
  localparam int unsigned MAX_SIZE_DEF = 128;
  localparam logic [DATA_W-1:0] GLYPH_HEIGHT_RST = 8'd128;
  localparam logic [DATA_W-1:0] COUNT_MAX = 8'd255;

  typedef enum logic [OP_W-1:0] {
    OP_ADD     = 2'd0,
    OP_RD_ROW  = 2'd1,
    OP_RD_COL  = 2'd2,
    OP_CLEAR   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROW_RD,
    ST_ROW_WR,
    ST_COL,
    ST_RD_ISSUE,
    ST_RD_RESP
  } state_e;

  // One profile entry: count plus low and high bound
  typedef struct packed {
    logic [DATA_W-1:0] cnt;
    logic [DATA_W-1:0] lo;
    logic [DATA_W-1:0] hi;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic latch;
    logic clear;
    logic row_rd;
    logic row_wr;
    logic col_step;
    logic rd_issue;
    logic out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    op_e  in_op;
    logic run_ok;
    logic col_done;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

@@ rtl/core/gpp_cmd_if.sv @@
`default_nettype none

interface gpp_cmd_if
  import gpp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [ROW_W-1:0]  run_row;
  logic [DATA_W-1:0] run_end;
  logic [DATA_W-1:0] run_length;

  modport source (output valid, opcode, run_row, run_end, run_length, input ready);
  modport sink (input valid, opcode, run_row, run_end, run_length, output ready);
endinterface

`default_nettype wire

@@ rtl/core/gpp_rsp_if.sv @@
`default_nettype none

interface gpp_rsp_if
  import gpp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] count;
  logic [DATA_W-1:0] low_bound;
  logic [DATA_W-1:0] high_bound;

  modport source (output valid, count, low_bound, high_bound, input ready);
  modport sink (input valid, count, low_bound, high_bound, output ready);
endinterface

`default_nettype wire

@@ rtl/core/glyph_projection_profiles.sv @@
// Add beat: row read-modify-write, then one column per cycle through the column memory port
//   (pipelined read/write); the next beat is accepted once the column sweep is done.
// Read beat: the entry is read, then loaded into the output register once that is free.
// Clear beat: touched flags reset at once. Rejected add runs return to idle without a write.
// Reset: asynchronous active low; tables read as empty, glyph height returns to 128.
`default_nettype none

module glyph_projection_profiles
  import gpp_pkg::*;
#(
  parameter int unsigned MAX_SIZE = MAX_SIZE_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [DATA_W-1:0] cfg_wdata_i,
  gpp_cmd_if.sink                cmd_i,
  gpp_rsp_if.source              rsp_o
);

  cmd_t    cmd;
  status_t status;
  entry_t  out_entry;

  gpp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cmd_i.valid),
    .in_ready_o (cmd_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  gpp_datapath #(
    .MAX_SIZE (MAX_SIZE)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_opcode_i     (cmd_i.opcode),
    .in_run_row_i    (cmd_i.run_row),
    .in_run_end_i    (cmd_i.run_end),
    .in_run_length_i (cmd_i.run_length),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_valid_o     (rsp_o.valid),
    .out_ready_i     (rsp_o.ready),
    .out_entry_o     (out_entry)
  );

  // Unpack the result beat
  assign rsp_o.count      = out_entry.cnt;
  assign rsp_o.low_bound  = out_entry.lo;
  assign rsp_o.high_bound = out_entry.hi;

endmodule

`default_nettype wire

@@ rtl/core/gpp_ctrl.sv @@
`default_nettype none

module gpp_ctrl
  import gpp_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          unique case (status_i.in_op)
            OP_ADD:    state_d = ST_ROW_RD;
            OP_RD_ROW: state_d = ST_RD_ISSUE;
            OP_RD_COL: state_d = ST_RD_ISSUE;
            OP_CLEAR:  cmd_o.clear = 1'b1;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_ROW_RD: begin
        // Drop runs that fall outside the tables
        if (status_i.run_ok) begin
          cmd_o.row_rd = 1'b1;
          state_d      = ST_ROW_WR;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_ROW_WR: begin
        cmd_o.row_wr = 1'b1;
        state_d      = ST_COL;
      end
      ST_COL: begin
        cmd_o.col_step = 1'b1;
        if (status_i.col_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_RD_ISSUE: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = ST_RD_RESP;
      end
      ST_RD_RESP: begin
        // Hold until the output register frees up
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/gpp_datapath.sv @@
`default_nettype none

module gpp_datapath
  import gpp_pkg::*;
#(
  parameter int unsigned MAX_SIZE = MAX_SIZE_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [DATA_W-1:0] cfg_wdata_i,
  input  wire logic [OP_W-1:0]   in_opcode_i,
  input  wire logic [ROW_W-1:0]  in_run_row_i,
  input  wire logic [DATA_W-1:0] in_run_end_i,
  input  wire logic [DATA_W-1:0] in_run_length_i,
  input  wire cmd_t              cmd_i,
  output status_t                status_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output entry_t                 out_entry_o
);

  localparam int unsigned IdxW = $clog2(MAX_SIZE);

  // Configuration
  logic [DATA_W-1:0] gh_q;

  // Latched item
  logic [ROW_W-1:0]  row_q;
  logic [DATA_W-1:0] end_q;
  logic [DATA_W-1:0] len_q;
  logic              rd_col_q;

  // Profile storage
  entry_t row_mem [MAX_SIZE];
  entry_t col_mem [MAX_SIZE];
  entry_t row_rdata_q;
  entry_t col_rdata_q;
  logic [MAX_SIZE-1:0] row_vld_q;
  logic [MAX_SIZE-1:0] col_vld_q;

  // Column sweep
  logic [DATA_W-1:0] x_q, x_d;
  logic              pend_q, pend_d;
  logic [IdxW-1:0]   paddr_q, paddr_d;

  // Read response
  logic   rd_vld_q;
  logic   idx_ok_q;
  logic   out_valid_q;
  entry_t out_entry_q;

  logic [DATA_W-1:0] y_full;
  logic [DATA_W-1:0] start;
  logic [DATA_W-1:0] idx_ext;
  logic [IdxW-1:0]   y_idx;
  logic [IdxW-1:0]   idx;
  logic              run_ok;
  logic              idx_ok;
  logic              x_more;
  logic [IdxW-1:0]   row_raddr;
  logic [IdxW-1:0]   col_raddr;
  logic              row_ren;
  logic              col_ren;
  logic [DATA_W:0]   row_sum;
  entry_t            row_new;
  entry_t            col_new;
  logic              row_v;
  logic              col_v;

  // Flip the row and qualify the run
  assign y_full  = gh_q - 8'd1 - DATA_W'(row_q);
  assign start   = end_q - len_q;
  assign y_idx   = y_full[IdxW-1:0];
  assign idx_ext = DATA_W'(row_q);
  assign idx     = idx_ext[IdxW-1:0];
  assign idx_ok  = (9'(row_q) < 9'(MAX_SIZE));
  assign run_ok  = (len_q != '0) && (len_q <= end_q) && (9'(end_q) <= 9'(MAX_SIZE))
                && (DATA_W'(row_q) < gh_q) && (9'(y_full) < 9'(MAX_SIZE));
  assign x_more  = (x_q != end_q);

  assign status_o.in_op    = op_e'(in_opcode_i);
  assign status_o.run_ok   = run_ok;
  assign status_o.col_done = !x_more && !pend_q;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gh_q <= GLYPH_HEIGHT_RST;
    end else if (cfg_we_i) begin
      gh_q <= cfg_wdata_i;
    end
  end

  // Capture the accepted beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      row_q    <= in_run_row_i;
      end_q    <= in_run_end_i;
      len_q    <= in_run_length_i;
      rd_col_q <= (op_e'(in_opcode_i) == OP_RD_COL);
    end
  end

  // Row entry update: add length, widen start and end
  assign row_v   = row_vld_q[y_idx];
  assign row_sum = (DATA_W+1)'(row_rdata_q.cnt) + (DATA_W+1)'(len_q);
  always_comb begin
    row_new.cnt = len_q;
    row_new.lo  = start;
    row_new.hi  = end_q;
    if (row_v) begin
      row_new.cnt = row_sum[DATA_W] ? COUNT_MAX : row_sum[DATA_W-1:0];
      if (row_rdata_q.lo < start) row_new.lo = row_rdata_q.lo;
      if (row_rdata_q.hi > end_q) row_new.hi = row_rdata_q.hi;
    end
  end

  // Column entry update: count one, widen low and high row
  assign col_v = col_vld_q[paddr_q];
  always_comb begin
    col_new.cnt = 8'd1;
    col_new.lo  = y_full;
    col_new.hi  = y_full;
    if (col_v) begin
      col_new.cnt = (col_rdata_q.cnt == COUNT_MAX) ? COUNT_MAX : col_rdata_q.cnt + 8'd1;
      if (col_rdata_q.lo < y_full) col_new.lo = col_rdata_q.lo;
      if (col_rdata_q.hi > y_full) col_new.hi = col_rdata_q.hi;
    end
  end

  // Read port address selection
  assign row_raddr = cmd_i.row_rd ? y_idx : idx;
  assign row_ren   = cmd_i.row_rd || cmd_i.rd_issue;
  assign col_raddr = cmd_i.col_step ? x_q[IdxW-1:0] : idx;
  assign col_ren   = (cmd_i.col_step && x_more) || cmd_i.rd_issue;

  // Row memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.row_wr) begin
      row_mem[y_idx] <= row_new;
    end
    if (row_ren) begin
      row_rdata_q <= row_mem[row_raddr];
    end
  end

  // Column memory
  always_ff @(posedge clk_i) begin
    if (pend_q) begin
      col_mem[paddr_q] <= col_new;
    end
    if (col_ren) begin
      col_rdata_q <= col_mem[col_raddr];
    end
  end

  // Touched flags; clear wipes all entries at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      col_vld_q <= '0;
    end else if (cmd_i.clear) begin
      row_vld_q <= '0;
      col_vld_q <= '0;
    end else begin
      if (cmd_i.row_wr) row_vld_q[y_idx] <= 1'b1;
      if (pend_q)       col_vld_q[paddr_q] <= 1'b1;
    end
  end

  // Column sweep: read one column while writing back the previous one
  always_comb begin
    x_d     = x_q;
    pend_d  = 1'b0;
    paddr_d = paddr_q;
    if (cmd_i.row_wr) begin
      x_d = start;
    end else if (cmd_i.col_step && x_more) begin
      pend_d  = 1'b1;
      paddr_d = x_q[IdxW-1:0];
      x_d     = x_q + 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    paddr_q <= paddr_d;
  end

  // Read response qualifiers
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_issue) begin
      idx_ok_q <= idx_ok;
      rd_vld_q <= rd_col_q ? col_vld_q[idx] : row_vld_q[idx];
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (idx_ok_q && rd_vld_q) begin
        out_entry_q <= rd_col_q ? col_rdata_q : row_rdata_q;
      end else begin
        out_entry_q <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_entry_o = out_entry_q;

`ifndef SYNTH
  a_col_wr_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (9'(paddr_q) < 9'(end_q)))
    else $error("column write outside the run");

  a_row_wr_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.row_wr |-> run_ok)
    else $error("row write for a rejected run");

  a_out_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result overwrites an unread beat");

  a_sweep_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.col_step && x_more) |=> (x_q == $past(x_q) + 8'd1))
    else $error("column sweep did not advance");
`endif

endmodule

`default_nettype wire
